/* src/brcd_pkg.sv */
// ----------------------------------------------------------------------------
// brcd_pkg: shared types and constants of the byte run-length decoder
// Field widths, length limits and the command word that passes from the
// front end to the back end through the command queue.
// ----------------------------------------------------------------------------
package brcd_pkg;

  localparam int LEN_W  = 21;
  localparam int CONS_W = 22;

  localparam logic [LEN_W-1:0]  MAX_DECODED = 21'h100000;
  localparam logic [LEN_W-1:0]  LEN_RESET   = 21'd4096;
  localparam logic [CONS_W-1:0] CONS_MAX    = 22'h3FFFFF;

  localparam logic [7:0] COUNT_MASK = 8'h7F;
  localparam logic [7:0] RUN_FLAG   = 8'h80;

  // Command queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // One decoded packet piece: value repeated take times
  typedef struct packed {
    logic [7:0]        value;
    logic [7:0]        take;
    logic              last;
    logic              over;
    logic [CONS_W-1:0] cons;
  } brcd_cmd_t;

endpackage

/* src/brcd_front.sv */
// ----------------------------------------------------------------------------
// brcd_front: byte classifier of the run-length decoder
// Takes compressed bytes, tracks packet phase and channel counters, and
// issues one command per kept literal byte or run value; leftover literals of a clipped packet give none.
// ----------------------------------------------------------------------------
module brcd_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [brcd_pkg::LEN_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte,
  input  logic                            room,
  output logic                            push,
  output brcd_pkg::brcd_cmd_t             cmd
);

  localparam logic [1:0] PH_CTRL = 2'd0;
  localparam logic [1:0] PH_LIT  = 2'd1;
  localparam logic [1:0] PH_RUNV = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  logic [brcd_pkg::LEN_W-1:0]  dec_len;
  logic [1:0]                  phase;
  logic [1:0]                  phase_next;
  logic [7:0]                  packet_left;
  logic [7:0]                  packet_left_next;
  logic [brcd_pkg::LEN_W-1:0]  produced;
  logic [brcd_pkg::LEN_W-1:0]  produced_next;
  logic [brcd_pkg::CONS_W-1:0] consumed;
  logic [brcd_pkg::CONS_W-1:0] consumed_next;

  logic                        acc;
  logic [brcd_pkg::LEN_W-1:0]  eff_len;
  logic [brcd_pkg::CONS_W-1:0] cons_inc;
  logic [7:0]                  pl_dec;
  logic [brcd_pkg::LEN_W-1:0]  prod_inc;
  logic                        lit_last;
  logic [brcd_pkg::LEN_W-1:0]  rem;
  logic [7:0]                  take;
  logic                        run_last;

  assign in_ready = room;
  assign acc      = in_valid & room;

  always_comb begin
    if (dec_len == '0) begin
      eff_len = brcd_pkg::LEN_W'(1);
    end else if (dec_len > brcd_pkg::MAX_DECODED) begin
      eff_len = brcd_pkg::MAX_DECODED;
    end else begin
      eff_len = dec_len;
    end
  end

  assign cons_inc = (consumed != brcd_pkg::CONS_MAX) ? consumed + 1'b1 : consumed;
  assign pl_dec   = (packet_left != 8'd0) ? packet_left - 8'd1 : 8'd0;
  assign prod_inc = produced + 1'b1;
  assign lit_last = prod_inc >= eff_len;
  assign rem      = (eff_len > produced) ? eff_len - produced : brcd_pkg::LEN_W'(1);
  assign run_last = {13'd0, packet_left} >= rem;
  assign take     = run_last ? rem[7:0] : packet_left;

  always_comb begin
    phase_next       = phase;
    packet_left_next = packet_left;
    produced_next    = produced;
    consumed_next    = consumed;
    push             = 1'b0;
    cmd.value        = in_byte;
    cmd.take         = 8'd1;
    cmd.last         = 1'b0;
    cmd.over         = 1'b0;
    cmd.cons         = cons_inc;
    if (acc) begin
      unique case (phase)
        PH_CTRL: begin
          consumed_next    = cons_inc;
          packet_left_next = (in_byte & brcd_pkg::COUNT_MASK) + 8'd1;
          phase_next       = ((in_byte & brcd_pkg::RUN_FLAG) != 8'd0) ? PH_RUNV : PH_LIT;
        end
        PH_LIT: begin
          push             = 1'b1;
          cmd.last         = lit_last;
          cmd.over         = pl_dec != 8'd0;
          packet_left_next = pl_dec;
          if (lit_last) begin
            produced_next = '0;
            consumed_next = '0;
            phase_next    = (pl_dec != 8'd0) ? PH_SKIP : PH_CTRL;
          end else begin
            produced_next = prod_inc;
            consumed_next = cons_inc;
            phase_next    = (pl_dec == 8'd0) ? PH_CTRL : PH_LIT;
          end
        end
        PH_RUNV: begin
          push             = 1'b1;
          cmd.take         = take;
          cmd.last         = run_last;
          cmd.over         = {13'd0, packet_left} > rem;
          packet_left_next = 8'd0;
          phase_next       = PH_CTRL;
          if (run_last) begin
            produced_next = '0;
            consumed_next = '0;
          end else begin
            produced_next = produced + {13'd0, take};
            consumed_next = cons_inc;
          end
        end
        PH_SKIP: begin
          // drop leftover literal bytes of a clipped packet, uncounted
          packet_left_next = pl_dec;
          if (pl_dec == 8'd0) begin
            phase_next = PH_CTRL;
          end
        end
        default: begin
          phase_next = PH_CTRL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_len     <= brcd_pkg::LEN_RESET;
      phase       <= PH_CTRL;
      packet_left <= 8'd0;
      produced    <= '0;
      consumed    <= '0;
    end else begin
      if (cfg_we) begin
        dec_len <= cfg_wdata;
      end
      phase       <= phase_next;
      packet_left <= packet_left_next;
      produced    <= produced_next;
      consumed    <= consumed_next;
    end
  end

endmodule

/* src/brcd_queue.sv */
// ----------------------------------------------------------------------------
// brcd_queue: command queue between front and back end
// Small register FIFO; head entry is presented without a read delay.
// ----------------------------------------------------------------------------
module brcd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  brcd_pkg::brcd_cmd_t   push_cmd,
  output logic                  room,
  input  logic                  pop,
  output logic                  head_valid,
  output brcd_pkg::brcd_cmd_t   head_cmd
);

  brcd_pkg::brcd_cmd_t       entries [brcd_pkg::Q_DEPTH];
  logic [brcd_pkg::Q_AW-1:0] wr_ptr;
  logic [brcd_pkg::Q_AW-1:0] rd_ptr;
  logic [brcd_pkg::Q_AW:0]   fill;

  assign room       = fill != (brcd_pkg::Q_AW+1)'(brcd_pkg::Q_DEPTH);
  assign head_valid = fill != '0;
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* src/brcd_back.sv */
// ----------------------------------------------------------------------------
// brcd_back: result expander of the run-length decoder
// Turns each command into results of up to two bytes and holds them in an
// output register for the downstream transfer.
// ----------------------------------------------------------------------------
module brcd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  brcd_pkg::brcd_cmd_t           head_cmd,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_first,
  output logic [7:0]                    out_second,
  output logic [1:0]                    out_count,
  output logic                          out_last,
  output logic                          out_over,
  output logic [brcd_pkg::CONS_W-1:0]   out_cons
);

  logic                cur_valid;
  brcd_pkg::brcd_cmd_t cur;
  logic                issue;
  logic                pair;
  logic                fin;

  assign issue = cur_valid & (~out_valid | out_ready);
  assign pair  = cur.take >= 8'd2;
  assign fin   = cur.take <= 8'd2;
  assign pop   = head_valid & (~cur_valid | (issue & fin));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (issue && fin) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_cmd;
    end else if (issue) begin
      cur.take <= cur.take - 8'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_first  <= cur.value;
      out_second <= pair ? cur.value : 8'd0;
      out_count  <= pair ? 2'd2 : 2'd1;
      out_last   <= fin & cur.last;
      out_over   <= fin & cur.last & cur.over;
      out_cons   <= (fin && cur.last) ? cur.cons : '0;
    end
  end

endmodule

/* src/byte_rle_channel_decoder_unit.sv */
// ----------------------------------------------------------------------------
// byte_rle_channel_decoder_unit: byte run-length decoder for one channel
// Expands a stream of compressed bytes (7-bit count, run flag in bit 7)
// into results of one or two decoded bytes, ending each channel at the
// configured decoded length.
//
// Usage:
//  - Slave stream: one compressed byte per transfer on s_tdata.
//  - Master stream: one result per transfer; m_tlast marks the result that
//    reaches the decoded length, m_tuser flags a clipped packet on it.
//  - cfg_we/cfg_wdata write the decoded length; write only while idle.
// Throughput: a byte is taken every cycle while the four-entry command
//  queue has room. A run value still needing n repetitions gives ceil(n/2)
//  results, one result per cycle unless m_tready stalls; control and dropped bytes give
//  no result. The output port of the back end sets the sustained rate.
// Path: a byte's command passes a queue entry, the back end's command
//  register and the output register; it waits while earlier commands expand.
// Reset: counters clear, the decoder waits for a control byte and the
//  decoded length returns to 4096.
// Stall: with m_tready low the result is held; the queue fills and then
//  s_tready drops until results drain.
// ----------------------------------------------------------------------------
module byte_rle_channel_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [brcd_pkg::LEN_W-1:0]    cfg_wdata,   // decoded_length
  // compressed byte stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,     // [7:0] in_byte
  // decoded result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [7:0] first_byte, [15:8] second_byte, [17:16] byte_count,
  // [39:18] bytes_consumed
  output logic [39:0]                   m_tdata,
  output logic                          m_tlast,     // last
  output logic                          m_tuser      // [0] overrun
);

  logic                          push;
  logic                          room;
  logic                          pop;
  logic                          head_valid;
  brcd_pkg::brcd_cmd_t           push_cmd;
  brcd_pkg::brcd_cmd_t           head_cmd;
  logic [7:0]                    res_first;
  logic [7:0]                    res_second;
  logic [1:0]                    res_count;
  logic [brcd_pkg::CONS_W-1:0]   res_cons;

  // Front end: classify bytes and update channel counters at each transfer
  brcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .room      (room),
    .push      (push),
    .cmd       (push_cmd)
  );

  // Decouple classification from expansion
  brcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .room       (room),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back end: expand commands into registered results
  brcd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_first  (res_first),
    .out_second (res_second),
    .out_count  (res_count),
    .out_last   (m_tlast),
    .out_over   (m_tuser),
    .out_cons   (res_cons)
  );

  // Pack the result fields, lowest field first
  assign m_tdata = {res_cons, res_count, res_second, res_first};

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the byte run-length channel decoder
// Drives compressed bytes into the slave stream, mirrors the decoder in a
// scoreboard that predicts every result, and compares each master-stream
// transfer field by field. Decoded lengths, handshake idling and receiver
// back-pressure change from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_HALF    = 2;
  localparam int RESET_LEN   = 9;
  localparam int DRAIN_TAIL  = 16;       // cycles after the last result
  localparam int CYCLE_LIMIT = 1000000;  // watchdog
  localparam int LONG_HOLD   = 300;      // receiver hold-off for back-pressure

  // Parser position inside the compressed stream
  typedef enum logic [1:0] {
    WAIT_CTRL,
    IN_LITERAL,
    WAIT_RUN_VALUE,
    DROP_LITERAL
  } parse_phase_t;

  // One decoded result as it leaves the master stream
  typedef struct packed {
    logic [7:0]                  first_byte;
    logic [7:0]                  second_byte;
    logic [1:0]                  byte_count;
    logic                        last;
    logic                        overrun;
    logic [brcd_pkg::CONS_W-1:0] bytes_consumed;
  } dec_result_t;

  // --------------------------------------------------------------------------
  // Decode tracker: follows every accepted byte, queues the results it must
  // cause and matches them against what the decoder sends.
  // --------------------------------------------------------------------------
  class rle_expect_board;
    logic [brcd_pkg::LEN_W-1:0]  length_reg;
    parse_phase_t                phase;
    int unsigned                 packet_left;
    int unsigned                 produced;
    logic [brcd_pkg::CONS_W-1:0] consumed;
    dec_result_t                 due[$];
    int unsigned                 errors;
    int unsigned                 results_seen;
    int unsigned                 channels_closed;

    function new();
      length_reg      = brcd_pkg::LEN_RESET;
      phase           = WAIT_CTRL;
      packet_left     = 0;
      produced        = 0;
      consumed        = '0;
      errors          = 0;
      results_seen    = 0;
      channels_closed = 0;
    endfunction

    function void set_length(logic [brcd_pkg::LEN_W-1:0] v);
      length_reg = v;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    // Zero acts as one, anything above the ceiling acts as the ceiling
    function int unsigned active_length();
      int unsigned len;
      len = 32'(length_reg);
      if (len < 1) len = 1;
      if (len > brcd_pkg::MAX_DECODED) len = 32'(brcd_pkg::MAX_DECODED);
      return len;
    endfunction

    function void bump_consumed();
      if (consumed != brcd_pkg::CONS_MAX) consumed++;
    endfunction

    function void push(logic [7:0] b0, logic [7:0] b1, logic [1:0] cnt,
                       logic lst, logic ovr, logic [brcd_pkg::CONS_W-1:0] cons);
      dec_result_t r;
      r.first_byte     = b0;
      r.second_byte    = b1;
      r.byte_count     = cnt;
      r.last           = lst;
      r.overrun        = ovr;
      r.bytes_consumed = cons;
      if (lst) channels_closed++;
      due = {due, r};
    endfunction

    // Note one accepted compressed byte and queue what it decodes to
    function void take_byte(logic [7:0] b);
      int unsigned len;
      int unsigned rem;
      int unsigned take;
      int unsigned done;
      int unsigned piece;
      bit          over;
      bit          closes;
      bit          fin;
      len = active_length();
      unique case (phase)
        DROP_LITERAL: begin
          // leftover literals of a clipped packet: swallow, do not count
          if (packet_left > 0) packet_left--;
          if (packet_left == 0) phase = WAIT_CTRL;
        end
        WAIT_CTRL: begin
          bump_consumed();
          packet_left = int'(b & brcd_pkg::COUNT_MASK) + 1;
          phase = ((b & brcd_pkg::RUN_FLAG) != 0) ? WAIT_RUN_VALUE : IN_LITERAL;
        end
        IN_LITERAL: begin
          bump_consumed();
          produced++;
          if (packet_left > 0) packet_left--;
          if (produced >= len) begin
            push(b, 8'h00, 2'd1, 1'b1, packet_left > 0, consumed);
            phase    = (packet_left > 0) ? DROP_LITERAL : WAIT_CTRL;
            produced = 0;
            consumed = '0;
          end else begin
            push(b, 8'h00, 2'd1, 1'b0, 1'b0, '0);
            if (packet_left == 0) phase = WAIT_CTRL;
          end
        end
        default: begin
          // run value: emit only the repetitions still needed, up to two per result
          rem    = (len > produced) ? (len - produced) : 1;
          take   = (packet_left < rem) ? packet_left : rem;
          closes = (take == rem);
          over   = (packet_left > rem);
          bump_consumed();
          if (take == 0) take = 1;
          done = 0;
          while (done < take) begin
            piece = (take - done >= 2) ? 2 : 1;
            done += piece;
            fin   = closes && (done >= take);
            push(b, (piece == 2) ? b : 8'h00, piece[1:0], fin, fin && over,
                 fin ? consumed : '0);
          end
          produced   += take;
          packet_left = 0;
          phase       = WAIT_CTRL;
          if (closes) begin
            produced = 0;
            consumed = '0;
          end
        end
      endcase
    endfunction

    function void report(string field, longint unsigned want,
                         longint unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, want, got);
    endfunction

    // Compare one master-stream transfer with the oldest queued result
    function void match_output(logic [39:0] data, logic tlast, logic tuser);
      dec_result_t want;
      results_seen++;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual data 0x%0h last %0b",
                 $time, data, tlast);
        return;
      end
      want = due.pop_front();
      if (data[7:0] != want.first_byte)
        report("first_byte", want.first_byte, data[7:0]);
      if (data[15:8] != want.second_byte)
        report("second_byte", want.second_byte, data[15:8]);
      if (data[17:16] != want.byte_count)
        report("byte_count", want.byte_count, data[17:16]);
      if (data[39:18] != want.bytes_consumed)
        report("bytes_consumed", want.bytes_consumed, data[39:18]);
      if (tlast != want.last)
        report("last", want.last, tlast);
      if (tuser != want.overrun)
        report("overrun", want.overrun, tuser);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [brcd_pkg::LEN_W-1:0] cfg_wdata;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [7:0]                 s_tdata;    // [7:0] in_byte
  logic                       m_tvalid;
  logic                       m_tready;
  // [7:0] first_byte, [15:8] second_byte, [17:16] byte_count,
  // [39:18] bytes_consumed
  logic [39:0]                m_tdata;
  logic                       m_tlast;    // last
  logic                       m_tuser;    // [0] overrun

  byte_rle_channel_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  rle_expect_board board;

  int unsigned tx_idle_pct;    // chance in a hundred that the sender idles
  int unsigned rx_idle_pct;    // chance in a hundred that the receiver stalls
  int unsigned hold_req;       // long hold-off asked of the receiver
  int unsigned hold_left;
  int unsigned items_sent;
  int unsigned settings_used;
  int unsigned cycles;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: end the run if the decoder stops making progress
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: decide tready at the falling edge, counting any long hold-off
  // here so the sender keeps offering bytes meanwhile
  initial begin
    m_tready  = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Sample every result transfer at the rising edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.match_output(m_tdata, m_tlast, m_tuser);
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks: each starts and ends at a falling edge
  // --------------------------------------------------------------------------

  // Offer one compressed byte, with random idle cycles in front, and hold
  // it until the transfer completes
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.take_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every queued result has come, then let the
  // pipeline settle for bytes that give no result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  // Write the decoded length; only call while the decoder is idle
  task automatic write_length(input logic [brcd_pkg::LEN_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.set_length(v);
    settings_used++;
  endtask

  // One packet with random content: mostly short, now and then full-size;
  // some literal packets are cut short and some items are pure noise.
  // Never send more than budget bytes.
  task automatic send_packet(input int unsigned budget);
    int unsigned roll;
    int unsigned cnt;
    int unsigned lits;
    logic [7:0]  ctrl;
    roll = $urandom_range(99);
    if (roll < 12 || budget < 2) begin
      send_byte(8'($urandom_range(255)));
    end else begin
      roll = $urandom_range(99);
      if (roll < 70)      cnt = $urandom_range(7);
      else if (roll < 92) cnt = $urandom_range(31, 8);
      else if (roll < 97) cnt = $urandom_range(126, 32);
      else                cnt = 127;
      ctrl = cnt[7:0];
      if ($urandom_range(1) == 1) ctrl = ctrl | brcd_pkg::RUN_FLAG;
      send_byte(ctrl);
      if ((ctrl & brcd_pkg::RUN_FLAG) != 0) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        lits = cnt + 1;
        if ($urandom_range(99) < 8) lits = $urandom_range(cnt);
        if (lits > budget - 1) lits = budget - 1;
        repeat (lits) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic random_stream(input int unsigned n);
    int unsigned target;
    target = items_sent + n;
    while (items_sent < target) send_packet(target - items_sent);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    board         = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_tvalid      = 1'b0;
    s_tdata       = 8'h00;
    hold_req      = 0;
    items_sent    = 0;
    settings_used = 0;
    tx_idle_pct   = 13;
    rx_idle_pct   = 84;

    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset length (4096): a full-size run of zeros and a one-byte literal
    // of all ones, far from the end of the channel
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);

    // Length zero acts as one; the channel is already past it, so the next
    // decoded byte must close it
    wait_drained();
    write_length('0);
    send_byte(8'h80);
    send_byte(8'h7E);

    // Length five: a literal packet then a run that ends the channel exactly
    wait_drained();
    write_length(21'd5);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'h81);
    send_byte(8'hA5);
    // Clipped literal: eight literals, five needed; the last three look like
    // control bytes but must be dropped
    send_byte(8'h07);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'h44);
    send_byte(8'h55);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h12);
    // Clipped run: 128 repetitions, five needed
    send_byte(8'hFF);
    send_byte(8'h3C);

    // Sender mostly busy, receiver mostly stalled
    wait_drained();
    write_length(21'd3);
    random_stream(45);
    wait_drained();
    write_length(21'd1);
    random_stream(30);
    wait_drained();
    write_length(brcd_pkg::LEN_W'($urandom_range(300, 2)));
    random_stream(40);

    // Sender mostly idle, receiver mostly ready
    tx_idle_pct = 84;
    rx_idle_pct = 13;
    wait_drained();
    write_length('1);   // above the ceiling, clamps to the maximum
    random_stream(30);
    // Lower the length mid-channel: the produced count already passes it
    wait_drained();
    write_length(21'd7);
    random_stream(20);
    // Pause the sender until every result is in, then carry on
    wait_drained();
    random_stream(20);
    wait_drained();
    write_length('0);
    random_stream(20);

    // No idling; start with a long receiver hold-off so the command queue
    // fills and s_tready drops while bytes are still offered
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_drained();
    write_length(21'd64);
    hold_req = LONG_HOLD;
    random_stream(60);
    wait_drained();
    write_length(brcd_pkg::LEN_W'($urandom_range(40, 1)));
    random_stream(42);

    wait_drained();
    $display("Sent %0d compressed bytes under %0d length settings and three idle profiles;",
             items_sent, settings_used);
    $display("checked %0d results, %0d channels closed.",
             board.results_seen, board.channels_closed);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
